// ----- sv/lcdns_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdns_pkg
// Types, constants and step tables shared by the character LCD sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

  localparam int CFG_W      = 16;
  localparam int WAIT_W     = 17;
  localparam int STEP_W     = 5;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 24;

  localparam logic [7:0] ROW0_BASE   = 8'h80;
  localparam logic [7:0] ROW1_BASE   = 8'hC0;
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_HOME    = 8'h02;
  localparam logic [7:0] CMD_FUNCSET = 8'h28;
  localparam logic [7:0] CMD_DISPON  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY   = 8'h06;
  localparam logic [3:0] INIT_NIB    = 4'h3;
  localparam logic [3:0] INIT_4BIT   = 4'h2;

  localparam logic [WAIT_W-1:0] INIT_GAP1_US = WAIT_W'(5000);
  localparam logic [WAIT_W-1:0] INIT_GAP2_US = WAIT_W'(150);

  localparam logic [STEP_W-1:0] BYTE_LAST  = STEP_W'(3);
  localparam logic [STEP_W-1:0] INIT_LAST  = STEP_W'(24);
  localparam logic [STEP_W-1:0] INIT_BYTE0 = STEP_W'(9);

  typedef enum logic [1:0] {
    ACT_COMMAND = 2'd0,
    ACT_DATA    = 2'd1,
    ACT_CURSOR  = 2'd2,
    ACT_INIT    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_ENABLE_HIGH = 2'd0,
    CFG_SETTLE      = 2'd1,
    CFG_LONG_CMD    = 2'd2,
    CFG_POWER_UP    = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    W_ENABLE,
    W_SETTLE,
    W_GAP_LONG,
    W_GAP_SHORT,
    W_LONG,
    W_POWER
  } wait_sel_t;

  typedef struct packed {
    logic [CFG_W-1:0] enable_high;
    logic [CFG_W-1:0] settle;
    logic [CFG_W-1:0] long_cmd;
    logic [CFG_W-1:0] power_up;
  } cfg_regs_t;

  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] byte_value;
    logic       long_cmd;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic              busy;
    logic [STEP_W-1:0] step;
  } back_status_t;

  typedef struct packed {
    logic      en;
    logic [3:0] nib;
    wait_sel_t wsel;
  } step_code_t;

  function automatic step_code_t byte_step(logic [7:0] b, logic long_cmd, logic [1:0] sub);
    step_code_t sc;
    sc.en   = ~sub[0];
    sc.nib  = sub[1] ? b[3:0] : b[7:4];
    sc.wsel = sub[0] ? ((sub[1] && long_cmd) ? W_LONG : W_SETTLE) : W_ENABLE;
    return sc;
  endfunction

  function automatic step_code_t init_step(logic [STEP_W-1:0] k);
    step_code_t        sc;
    logic [STEP_W-1:0] j;
    logic [1:0]        pair;
    logic [7:0]        b;
    sc   = '{en: 1'b0, nib: 4'h0, wsel: W_POWER};
    j    = '0;
    pair = '0;
    b    = CMD_FUNCSET;
    if (k == '0) begin
      sc = '{en: 1'b0, nib: 4'h0, wsel: W_POWER};
    end else if (k < INIT_BYTE0) begin
      j       = k - STEP_W'(1);
      pair    = j[2:1];
      sc.en   = ~j[0];
      sc.nib  = (pair == 2'd3) ? INIT_4BIT : INIT_NIB;
      if (!j[0]) begin
        sc.wsel = W_ENABLE;
      end else if (pair == 2'd0) begin
        sc.wsel = W_GAP_LONG;
      end else if (pair == 2'd3) begin
        sc.wsel = W_SETTLE;
      end else begin
        sc.wsel = W_GAP_SHORT;
      end
    end else begin
      j = k - INIT_BYTE0;
      case (j[3:2])
        2'd0:    b = CMD_FUNCSET;
        2'd1:    b = CMD_DISPON;
        2'd2:    b = CMD_ENTRY;
        default: b = CMD_CLEAR;
      endcase
      sc = byte_step(b, j[3:2] == 2'd3, j[1:0]);
    end
    return sc;
  endfunction

endpackage

// ----- sv/char_lcd_nibble_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// Character LCD request sequencer for a 4-bit bus with timed pin steps.
// ----------------------------------------------------------------------------
// Each request becomes a run of pin steps, one step per cycle from the step
// sequencer while the receiver takes them; an initialise request has a longer
// run than a command, data or cursor request. A four-entry job queue lets
// requests be taken while the sequencer works. The output register is
// reloaded in the same cycle that its step is taken, so a stalled step holds
// the sequencer, and steps go out back to back once the receiver takes them.
// Register writes must be made only while no request is in flight.
module char_lcd_nibble_sequencer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [lcdns_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lcdns_pkg::S_TDATA_W-1:0] s_tdata,  // byte_value, row_select, column
  input  logic [1:0]                      s_tuser,  // action
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lcdns_pkg::M_TDATA_W-1:0] m_tdata,  // enable_level, data_nibble, wait_us
  output logic                            m_tuser,  // register_select
  output logic                            m_tlast   // last
);
  import lcdns_pkg::*;

  cfg_regs_t    cfg;
  logic         push;
  logic         pop;
  job_t         job;
  job_t         head;
  q_status_t    q_st;
  back_status_t back_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_high <= CFG_W'(1);
      cfg.settle      <= CFG_W'(100);
      cfg.long_cmd    <= CFG_W'(2000);
      cfg.power_up    <= CFG_W'(40000);
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_ENABLE_HIGH: cfg.enable_high <= cfg_wdata;
        CFG_SETTLE:      cfg.settle      <= cfg_wdata;
        CFG_LONG_CMD:    cfg.long_cmd    <= cfg_wdata;
        CFG_POWER_UP:    cfg.power_up    <= cfg_wdata;
        default:         cfg             <= cfg;
      endcase
    end
  end

  lcdns_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_st     (q_st),
    .push     (push),
    .job      (job)
  );

  lcdns_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .job_in (job),
    .pop    (pop),
    .head   (head),
    .q_st   (q_st)
  );

  lcdns_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .q_st     (q_st),
    .pop      (pop),
    .back_st  (back_st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_last_enable_low : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[0])
    else $error("final step of a request has enable high");

  a_data_no_long_wait : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[21])
    else $error("data byte step carries a long wait");

  a_step_needs_job : assert property (@(posedge clk) disable iff (rst)
    back_st.step != '0 |-> back_st.busy)
    else $error("sequencer mid-request with an empty queue");

  a_accept_fills_queue : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !q_st.empty)
    else $error("accepted request did not reach the queue");

endmodule

// ----- sv/lcdns_front.sv -----
// ----------------------------------------------------------------------------
// lcdns_front
// Accepts requests, works out the byte to send and queues one job per request.
// ----------------------------------------------------------------------------
module lcdns_front (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lcdns_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [1:0]                     s_tuser,
  input  lcdns_pkg::q_status_t           q_st,
  output logic                           push,
  output lcdns_pkg::job_t                job
);
  import lcdns_pkg::*;

  logic [7:0] byte_in;
  logic       row;
  logic [7:0] col;
  logic [7:0] addr;
  action_t    act;

  assign byte_in  = s_tdata[7:0];
  assign row      = s_tdata[8];
  assign col      = s_tdata[16:9];
  assign act      = action_t'(s_tuser);
  assign addr     = (row ? ROW1_BASE : ROW0_BASE) + col;
  assign s_tready = ~q_st.full;
  assign push     = s_tvalid & s_tready;

  always_comb begin
    job = '{is_init: 1'b0, rs: 1'b0, byte_value: byte_in, long_cmd: 1'b0};
    case (act)
      ACT_COMMAND: begin
        job.long_cmd = (byte_in == CMD_CLEAR) || (byte_in == CMD_HOME);
      end
      ACT_DATA: begin
        job.rs = 1'b1;
      end
      ACT_CURSOR: begin
        job.byte_value = addr;
        job.long_cmd   = (addr == CMD_CLEAR) || (addr == CMD_HOME);
      end
      default: begin
        job.is_init = 1'b1;
      end
    endcase
  end

endmodule

// ----- sv/lcdns_queue.sv -----
// ----------------------------------------------------------------------------
// lcdns_queue
// Short job queue between the request front end and the step sequencer.
// ----------------------------------------------------------------------------
module lcdns_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lcdns_pkg::job_t      job_in,
  input  logic                 pop,
  output lcdns_pkg::job_t      head,
  output lcdns_pkg::q_status_t q_st
);
  import lcdns_pkg::*;

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign q_st.empty = (count == '0);
  assign q_st.full  = (count == QCNT_W'(QDEPTH));
  assign do_push    = push & ~q_st.full;
  assign do_pop     = pop & ~q_st.empty;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= job_in;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/lcdns_back.sv -----
// ----------------------------------------------------------------------------
// lcdns_back
// Step sequencer: turns the queue head job into pin steps, one a cycle unless stalled.
// ----------------------------------------------------------------------------
module lcdns_back (
  input  logic                            clk,
  input  logic                            rst,
  input  lcdns_pkg::cfg_regs_t            cfg,
  input  lcdns_pkg::job_t                 head,
  input  lcdns_pkg::q_status_t            q_st,
  output logic                            pop,
  output lcdns_pkg::back_status_t         back_st,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lcdns_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                            m_tuser,
  output logic                            m_tlast
);
  import lcdns_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              out_free;
  logic              fire;
  logic              is_last;
  step_code_t        sc;
  logic [WAIT_W-1:0] settle_w;
  logic [WAIT_W-1:0] wait_val;
  logic              out_rs;
  logic              out_en;
  logic [3:0]        out_nib;
  logic [WAIT_W-1:0] out_wait;
  logic              out_last;

  assign out_free = ~m_tvalid | m_tready;
  assign fire     = ~q_st.empty & out_free;
  assign is_last  = head.is_init ? (step == INIT_LAST) : (step == BYTE_LAST);
  assign pop      = fire & is_last;
  assign settle_w = WAIT_W'(cfg.settle);

  always_comb begin
    if (head.is_init) begin
      sc = init_step(step);
    end else begin
      sc = byte_step(head.byte_value, head.long_cmd, step[1:0]);
    end
  end

  // Every sum is of two values below 2^16, so none reaches the 17-bit limit.
  always_comb begin
    case (sc.wsel)
      W_ENABLE:    wait_val = WAIT_W'(cfg.enable_high);
      W_SETTLE:    wait_val = settle_w;
      W_GAP_LONG:  wait_val = settle_w + INIT_GAP1_US;
      W_GAP_SHORT: wait_val = settle_w + INIT_GAP2_US;
      W_LONG:      wait_val = settle_w + WAIT_W'(cfg.long_cmd);
      W_POWER:     wait_val = WAIT_W'(cfg.power_up);
      default:     wait_val = settle_w;
    endcase
  end

  always_comb begin
    step_next = step;
    if (fire) begin
      step_next = is_last ? '0 : step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rs   <= head.rs;
      out_en   <= sc.en;
      out_nib  <= sc.nib;
      out_wait <= wait_val;
      out_last <= is_last;
    end
    if (rst) begin
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      step <= step_next;
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign back_st.busy = ~q_st.empty;
  assign back_st.step = step;

  // m_tdata: enable_level, data_nibble, wait_us, zero fill.
  assign m_tdata = {{(M_TDATA_W - WAIT_W - 5){1'b0}}, out_wait, out_nib, out_en};
  assign m_tuser = out_rs;
  assign m_tlast = out_last;

endmodule
